// ===== sv/mbgf_pkg.sv =====
`timescale 1ns / 1ps

package mbgf_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int PRICE_W  = 32;
    localparam int GAP_W    = 7;

    localparam int MAX_FILLERS = 63;
    localparam int FILL_CNT_W  = $clog2(MAX_FILLERS + 1);

    // day number and minute number, signed: year 0, day 0 lands below zero
    localparam int DAYS_W = 24;
    localparam int MINS_W = 36;
    localparam int HM_W   = 11;

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_EN = 1'b1;

    localparam logic [GAP_W-1:0] MAX_GAP_RESET = 7'd65;

    localparam logic signed [MINS_W-1:0] MIN_PER_DAY  = 36'sd1440;
    localparam logic [HM_W-1:0]          MIN_PER_HOUR = 11'd60;
    localparam logic [8:0]               DAYS_PER_YEAR = 9'd365;

    // first member sits in the high bits: year ends up at bit 0
    typedef struct packed {
        logic [PRICE_W-1:0] close;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] high;
        logic [PRICE_W-1:0] open;
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } bar_t;

    localparam int BAR_W = $bits(bar_t);

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
    } stamp_t;

    // one queued job: the bar, how many fillers go ahead of it, and where they start
    typedef struct packed {
        bar_t                  bar;
        logic [FILL_CNT_W-1:0] fill_cnt;
        stamp_t                prev;
        logic [PRICE_W-1:0]    prev_close;
    } entry_t;

    // days before month idx+1 in a common year
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

    // invalid months run 31 days
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo,
                                                   input logic leap);
        logic [DAY_W-1:0] n;
        case (mo)
            4'd2:                      n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

// ===== sv/minute_bar_gap_filler.sv =====
`timescale 1ns / 1ps

// Minute bar gap filler. Takes one-minute price bars in time order and, when
// the distance to the previous bar is more than one minute but below max_gap,
// sends gap-1 filler bars (one minute apart, seconds 0, all prices equal to the
// previous close, tuser high) ahead of the bar itself, which goes out unchanged
// with tlast high. At most 63 fillers per bar. Every year divisible by 4 counts
// as a leap year. Flow: for each bar the front sequencer steps through accept,
// day number, minute number, difference and queue push, and takes no new bar
// until the push, which waits while the queue is full; the back end loads a job
// and then sends one beat per cycle while m_tready is high. A 2-entry queue
// lets the front compute ahead while fillers drain.
// Write max_gap and gap_fill_enable only while no bar is in flight.

module minute_bar_gap_filler (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_we,
    input  logic [mbgf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbgf_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28]
    // second[39:34] open[71:40] high[103:72] low[135:104] close[167:136]
    input  logic [mbgf_pkg::BAR_W-1:0]         s_tdata,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // same layout as s_tdata
    output logic [mbgf_pkg::BAR_W-1:0]         m_tdata,
    output logic                               m_tlast,   // last beat caused by a bar
    output logic                               m_tuser    // is_filler
);

    logic [mbgf_pkg::GAP_W-1:0] max_gap_reg;
    logic                       fill_en_reg;

    logic                       push, pop, q_full, q_empty;
    mbgf_pkg::entry_t           push_entry, pop_entry;
    mbgf_pkg::bar_t             m_bar;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_gap_reg <= mbgf_pkg::MAX_GAP_RESET;
            fill_en_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                mbgf_pkg::REG_MAX_GAP: max_gap_reg <= cfg_data[mbgf_pkg::GAP_W-1:0];
                mbgf_pkg::REG_FILL_EN: fill_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front: timestamp to minute number, gap test, filler count
    mbgf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_bar      (mbgf_pkg::bar_t'(s_tdata)),
        .max_gap    (max_gap_reg),
        .fill_en    (fill_en_reg),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    // job queue between the two halves
    mbgf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    // back: filler clock and output register
    mbgf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_entry  (pop_entry),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_bar    (m_bar),
        .m_filler (m_tuser),
        .m_last   (m_tlast)
    );

    assign m_tdata = m_bar;

endmodule

// ===== sv/mbgf_front.sv =====
`timescale 1ns / 1ps

module mbgf_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  mbgf_pkg::bar_t                      s_bar,
    input  logic [mbgf_pkg::GAP_W-1:0]          max_gap,
    input  logic                                fill_en,
    output logic                                push,
    output mbgf_pkg::entry_t                    push_entry,
    input  logic                                q_full
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_DAYS = 5'b00010,
        F_MINS = 5'b00100,
        F_DIFF = 5'b01000,
        F_PUSH = 5'b10000
    } fstate_t;

    fstate_t state_reg, state_next;

    mbgf_pkg::bar_t                          bar_reg;
    logic signed [mbgf_pkg::DAYS_W-1:0]      days_reg, days_next;
    logic [mbgf_pkg::HM_W-1:0]               hm_reg, hm_next;
    logic signed [mbgf_pkg::MINS_W-1:0]      mins_reg, mins_next;
    logic signed [mbgf_pkg::MINS_W-1:0]      d_ba_reg, d_ab_reg;
    logic signed [mbgf_pkg::MINS_W-1:0]      prev_abs_reg;
    logic                                    have_prev_reg;
    mbgf_pkg::stamp_t                        prev_reg;
    logic [mbgf_pkg::PRICE_W-1:0]            prev_close_reg;

    logic [mbgf_pkg::DAYS_W-2:0]             days_sum;
    logic [mbgf_pkg::YEAR_W:0]               year_p3;
    logic [mbgf_pkg::MONTH_W-1:0]            idx;
    logic [9:0]                              doy;
    logic signed [mbgf_pkg::MINS_W-1:0]      days_ext, hm_ext;
    logic [mbgf_pkg::MINS_W-1:0]             gap;
    logic                                    gap_small, fill;
    logic [mbgf_pkg::GAP_W-1:0]              gap_lo, gap_m1;
    logic [mbgf_pkg::FILL_CNT_W-1:0]         fill_cnt;

    assign s_tready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && !q_full;

    // day number: y*365 + leap days before y + day of year - 1
    always_comb begin
        year_p3 = {1'b0, bar_reg.year} + (mbgf_pkg::YEAR_W+1)'(3);
        if (bar_reg.month > 4'd1) begin
            idx = (bar_reg.month >= 4'd13) ? 4'd12 : bar_reg.month - 4'd1;
            doy = 10'(mbgf_pkg::days_before(idx)) + 10'(bar_reg.day)
                + 10'((bar_reg.year[1:0] == 2'b00) && (bar_reg.month > 4'd2));
        end else begin
            idx = '0;
            doy = 10'(bar_reg.day);
        end
        days_sum = (mbgf_pkg::DAYS_W-1)'(bar_reg.year) * (mbgf_pkg::DAYS_W-1)'(mbgf_pkg::DAYS_PER_YEAR)
                 + (mbgf_pkg::DAYS_W-1)'(year_p3 >> 2) + (mbgf_pkg::DAYS_W-1)'(doy);
        days_next = $signed({1'b0, days_sum}) - mbgf_pkg::DAYS_W'(1);
        hm_next   = mbgf_pkg::HM_W'(bar_reg.hour) * mbgf_pkg::MIN_PER_HOUR
                  + mbgf_pkg::HM_W'(bar_reg.minute);
    end

    always_comb begin
        days_ext  = mbgf_pkg::MINS_W'(days_reg);
        hm_ext    = mbgf_pkg::MINS_W'(hm_reg);
        mins_next = days_ext * mbgf_pkg::MIN_PER_DAY + hm_ext;
    end

    // gap test: only magnitudes below 128 can ever fill
    always_comb begin
        gap       = d_ba_reg[mbgf_pkg::MINS_W-1] ? d_ab_reg : d_ba_reg;
        gap_small = (gap[mbgf_pkg::MINS_W-1:mbgf_pkg::GAP_W] == '0);
        gap_lo    = gap[mbgf_pkg::GAP_W-1:0];
        gap_m1    = gap_lo - mbgf_pkg::GAP_W'(1);
        fill      = have_prev_reg && fill_en && gap_small
                 && (gap_lo > mbgf_pkg::GAP_W'(1)) && (gap_lo < max_gap);
        if (!fill)
            fill_cnt = '0;
        else if (gap_m1 > mbgf_pkg::GAP_W'(mbgf_pkg::MAX_FILLERS))
            fill_cnt = mbgf_pkg::FILL_CNT_W'(mbgf_pkg::MAX_FILLERS);
        else
            fill_cnt = mbgf_pkg::FILL_CNT_W'(gap_m1);
    end

    always_comb begin
        push_entry.bar        = bar_reg;
        push_entry.fill_cnt   = fill_cnt;
        push_entry.prev       = prev_reg;
        push_entry.prev_close = prev_close_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) state_next = F_DAYS;
            end
            F_DAYS: state_next = F_MINS;
            F_MINS: state_next = F_DIFF;
            F_DIFF: state_next = F_PUSH;
            F_PUSH: begin
                if (!q_full) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            have_prev_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (push) have_prev_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) bar_reg <= s_bar;
        if (state_reg == F_DAYS) begin
            days_reg <= days_next;
            hm_reg   <= hm_next;
        end
        if (state_reg == F_MINS) mins_reg <= mins_next;
        if (state_reg == F_DIFF) begin
            d_ba_reg <= mins_reg - prev_abs_reg;
            d_ab_reg <= prev_abs_reg - mins_reg;
        end
        if (push) begin
            prev_abs_reg   <= mins_reg;
            prev_reg.year   <= bar_reg.year;
            prev_reg.month  <= bar_reg.month;
            prev_reg.day    <= bar_reg.day;
            prev_reg.hour   <= bar_reg.hour;
            prev_reg.minute <= bar_reg.minute;
            prev_close_reg <= bar_reg.close;
        end
    end

endmodule

// ===== sv/mbgf_queue.sv =====
`timescale 1ns / 1ps

module mbgf_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  mbgf_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output mbgf_pkg::entry_t pop_entry,
    output logic             empty
);

    localparam int PTR_W = (mbgf_pkg::QUEUE_DEPTH > 1) ? $clog2(mbgf_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mbgf_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(mbgf_pkg::QUEUE_DEPTH - 1);

    mbgf_pkg::entry_t   mem_reg [mbgf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = (count_reg == CNT_W'(mbgf_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== sv/mbgf_back.sv =====
`timescale 1ns / 1ps

module mbgf_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  mbgf_pkg::entry_t q_entry,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output mbgf_pkg::bar_t   m_bar,
    output logic             m_filler,
    output logic             m_last
);

    logic                            busy_reg;
    logic [mbgf_pkg::FILL_CNT_W-1:0] cnt_reg;
    mbgf_pkg::stamp_t                cur_reg, tick;
    logic [mbgf_pkg::PRICE_W-1:0]    close_reg;
    mbgf_pkg::bar_t                  bar_reg, filler_bar;

    logic                            out_valid_reg, out_valid_next;
    mbgf_pkg::bar_t                  out_bar_reg;
    logic                            out_filler_reg, out_last_reg;

    logic                            out_free, emit;
    logic [mbgf_pkg::MIN_W:0]        min1;
    logic [mbgf_pkg::HOUR_W:0]       hr1;
    logic [mbgf_pkg::DAY_W:0]        day1;
    logic [mbgf_pkg::MONTH_W:0]      mo1;
    logic [mbgf_pkg::DAY_W-1:0]      limit;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = !busy_reg && !q_empty;
    assign emit     = busy_reg && out_free;

    assign m_tvalid = out_valid_reg;
    assign m_bar    = out_bar_reg;
    assign m_filler = out_filler_reg;
    assign m_last   = out_last_reg;

    // one-minute tick of the filler clock
    always_comb begin
        tick  = cur_reg;
        min1  = {1'b0, cur_reg.minute} + (mbgf_pkg::MIN_W+1)'(1);
        hr1   = {1'b0, cur_reg.hour} + (mbgf_pkg::HOUR_W+1)'(1);
        day1  = {1'b0, cur_reg.day} + (mbgf_pkg::DAY_W+1)'(1);
        mo1   = {1'b0, cur_reg.month} + (mbgf_pkg::MONTH_W+1)'(1);
        limit = mbgf_pkg::month_len(cur_reg.month, cur_reg.year[1:0] == 2'b00);
        if (min1 < (mbgf_pkg::MIN_W+1)'(60)) begin
            tick.minute = min1[mbgf_pkg::MIN_W-1:0];
        end else begin
            tick.minute = '0;
            if (hr1 < (mbgf_pkg::HOUR_W+1)'(24)) begin
                tick.hour = hr1[mbgf_pkg::HOUR_W-1:0];
            end else begin
                tick.hour = '0;
                if (day1 > {1'b0, limit}) begin
                    tick.day = mbgf_pkg::DAY_W'(1);
                    if (mo1 > (mbgf_pkg::MONTH_W+1)'(12)) begin
                        tick.month = mbgf_pkg::MONTH_W'(1);
                        tick.year  = cur_reg.year + mbgf_pkg::YEAR_W'(1);
                    end else begin
                        tick.month = mo1[mbgf_pkg::MONTH_W-1:0];
                    end
                end else begin
                    tick.day = day1[mbgf_pkg::DAY_W-1:0];
                end
            end
        end
    end

    always_comb begin
        filler_bar.year   = tick.year;
        filler_bar.month  = tick.month;
        filler_bar.day    = tick.day;
        filler_bar.hour   = tick.hour;
        filler_bar.minute = tick.minute;
        filler_bar.second = '0;
        filler_bar.open   = close_reg;
        filler_bar.high   = close_reg;
        filler_bar.low    = close_reg;
        filler_bar.close  = close_reg;
    end

    always_comb begin
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
                busy_reg <= 1'b1;
            else if (emit && (cnt_reg == '0))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cnt_reg   <= q_entry.fill_cnt;
            cur_reg   <= q_entry.prev;
            close_reg <= q_entry.prev_close;
            bar_reg   <= q_entry.bar;
        end else if (emit) begin
            if (cnt_reg != '0) begin
                cnt_reg        <= cnt_reg - mbgf_pkg::FILL_CNT_W'(1);
                cur_reg        <= tick;
                out_bar_reg    <= filler_bar;
                out_filler_reg <= 1'b1;
                out_last_reg   <= 1'b0;
            end else begin
                out_bar_reg    <= bar_reg;
                out_filler_reg <= 1'b0;
                out_last_reg   <= 1'b1;
            end
        end
    end

endmodule

// ===== test/minute_bar_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams and the register port, predicts every beat that the
// gap filler owes, and checks each output beat against the oldest one due.
module minute_bar_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mbgf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbgf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mbgf_pkg::BAR_W-1:0]      s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mbgf_pkg::BAR_W-1:0]      m_tdata,
    input  logic                            m_tlast,
    input  logic                            m_tuser,
    output int                              pending,
    output int                              errors,
    output int                              filler_beats
);
    import mbgf_pkg::*;

    typedef struct {
        bar_t bar;
        logic filler;
        logic last;
    } beat_t;

    beat_t bars_due[$];
    int    beats_seen;

    // register copies
    int   gap_limit;
    logic fill_on;

    // last bar seen on the input
    logic        have_prev;
    int          p_year, p_month, p_day, p_hour, p_min;
    logic [31:0] p_close;

    function automatic int days_ahead(input int idx);
        case (idx)
            0:       return 0;
            1:       return 31;
            2:       return 59;
            3:       return 90;
            4:       return 120;
            5:       return 151;
            6:       return 181;
            7:       return 212;
            8:       return 243;
            9:       return 273;
            10:      return 304;
            11:      return 334;
            default: return 365;
        endcase
    endfunction

    // out-of-range months run 31 days
    function automatic int month_span(input int mo, input int y);
        if (mo == 2 && y % 4 == 0) return 29;
        case (mo)
            2:           return 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic longint minute_number(input int y, input int mo, input int d,
                                             input int h, input int mi);
        longint days, doy;
        days = longint'(y) * 365 + (y + 3) / 4;
        if (mo > 1) begin
            doy = days_ahead((mo > 13) ? 12 : mo - 1) + d;
            if (y % 4 == 0 && mo > 2) doy++;
        end else begin
            doy = d;
        end
        return (days + doy - 1) * 1440 + longint'(h) * 60 + mi;
    endfunction

    task automatic tick_previous();
        p_min++;
        if (p_min < 60) return;
        p_min = 0;
        p_hour++;
        if (p_hour < 24) return;
        p_hour = 0;
        p_day++;
        if (p_day > month_span(p_month, p_year)) begin
            p_day = 1;
            p_month++;
            if (p_month > 12) begin
                p_month = 1;
                p_year  = (p_year + 1) & 16'h3FFF;
            end
        end
        p_day = p_day & 5'h1F;
    endtask

    task automatic predict_bar(input bar_t b);
        longint now_min, prev_min, gap;
        int     n;
        beat_t  e;
        if (have_prev && fill_on) begin
            prev_min = minute_number(p_year, p_month, p_day, p_hour, p_min);
            now_min  = minute_number(b.year, b.month, b.day, b.hour, b.minute);
            gap = (now_min > prev_min) ? now_min - prev_min : prev_min - now_min;
            if (gap > 1 && gap < gap_limit) begin
                n = (gap - 1 > MAX_FILLERS) ? MAX_FILLERS : int'(gap - 1);
                repeat (n) begin
                    tick_previous();
                    e.bar        = '0;
                    e.bar.year   = p_year[YEAR_W-1:0];
                    e.bar.month  = p_month[MONTH_W-1:0];
                    e.bar.day    = p_day[DAY_W-1:0];
                    e.bar.hour   = p_hour[HOUR_W-1:0];
                    e.bar.minute = p_min[MIN_W-1:0];
                    e.bar.open   = p_close;
                    e.bar.high   = p_close;
                    e.bar.low    = p_close;
                    e.bar.close  = p_close;
                    e.filler     = 1'b1;
                    e.last       = 1'b0;
                    bars_due.insert(bars_due.size(), e);
                end
            end
        end
        e.bar    = b;
        e.filler = 1'b0;
        e.last   = 1'b1;
        bars_due.insert(bars_due.size(), e);
        have_prev = 1'b1;
        p_year    = b.year;
        p_month   = b.month;
        p_day     = b.day;
        p_hour    = b.hour;
        p_min     = b.minute;
        p_close   = b.close;
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s got %0h expected %0h",
                                      beats_seen, name, got, want));
    endtask

    task automatic check_beat();
        bar_t  got;
        beat_t want;
        got = m_tdata;
        beats_seen++;
        if (bars_due.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with nothing due: %h",
                                      beats_seen, m_tdata));
            return;
        end
        want = bars_due.pop_front();
        compare_field("year",      got.year,   want.bar.year);
        compare_field("month",     got.month,  want.bar.month);
        compare_field("day",       got.day,    want.bar.day);
        compare_field("hour",      got.hour,   want.bar.hour);
        compare_field("minute",    got.minute, want.bar.minute);
        compare_field("second",    got.second, want.bar.second);
        compare_field("open",      got.open,   want.bar.open);
        compare_field("high",      got.high,   want.bar.high);
        compare_field("low",       got.low,    want.bar.low);
        compare_field("close",     got.close,  want.bar.close);
        compare_field("is_filler", m_tuser,    want.filler);
        compare_field("tlast",     m_tlast,    want.last);
        if (want.filler) filler_beats++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            gap_limit = MAX_GAP_RESET;
            fill_on   = 1'b1;
            have_prev = 1'b0;
            p_year    = 0;
            p_month   = 1;
            p_day     = 1;
            p_hour    = 0;
            p_min     = 0;
            p_close   = '0;
            bars_due.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_MAX_GAP) gap_limit = cfg_data;
                else if (cfg_index == REG_FILL_EN) fill_on = cfg_data[0];
            end
            if (s_tvalid && s_tready) predict_bar(s_tdata);
            if (m_tvalid && m_tready) check_beat();
        end
        pending <= bars_due.size();
    end

endmodule

// ===== test/minute_bar_gap_filler_tb.sv =====
`timescale 1ns / 1ps

// Top of the gap filler bench: clock, reset, register writes, bar stimulus
// and output back-pressure. All checking lives in minute_bar_checker.
module minute_bar_gap_filler_tb;
    import mbgf_pkg::*;

    // overall run limit, with a wide margin over the slowest legal run
    localparam int RUN_LIMIT = 300000;
    // let the front sequencer settle before a register write
    localparam int SETTLE    = 12;
    localparam int HOLD_OFF  = 400;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    bar_t                  s_tdata   = '0;   // year, month, day, hour, minute, second,
                                             // open, high, low, close (low bits first)
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [BAR_W-1:0]      m_tdata;          // same layout as s_tdata
    logic                  m_tlast;
    logic                  m_tuser;          // is_filler

    int pending, errors, filler_beats;

    // idle odds in percent, per cycle, for each side
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // long output hold: kicked once by the stimulus, timed by its own process
    logic stall_go   = 1'b0;
    logic stall_hold = 1'b0;

    int bars_sent      = 0;
    int settings_used  = 0;
    int cur_gap        = MAX_GAP_RESET;

    // walking timestamp for well-formed bar sequences
    int cur_year = 2000, cur_mon = 1, cur_day = 1, cur_hour = 0, cur_min = 0;

    minute_bar_gap_filler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    minute_bar_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .pending      (pending),
        .errors       (errors),
        .filler_beats (filler_beats)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        repeat (RUN_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    // output back-pressure: random idles, forced low during the long hold
    always @(posedge aclk) begin
        if (stall_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // once kicked, hold the output for a fixed stretch so the block backs up
    // into its input
    initial begin
        wait (stall_go);
        stall_hold <= 1'b1;
        repeat (HOLD_OFF) @(posedge aclk);
        stall_hold <= 1'b0;
    end

    // valid calendar, every fourth year leap; only used to walk the cursor
    function automatic int month_days(input int y, input int mo);
        case (mo)
            2:           return (y % 4 == 0) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic logic [31:0] pick_price();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 32'h0;
        if (r < 16) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic bar_t make_bar(input int y, input int mo, input int d,
                                      input int h, input int mi, input int s,
                                      input logic [31:0] op, input logic [31:0] hi,
                                      input logic [31:0] lo, input logic [31:0] cl);
        bar_t b;
        b.year   = y[YEAR_W-1:0];
        b.month  = mo[MONTH_W-1:0];
        b.day    = d[DAY_W-1:0];
        b.hour   = h[HOUR_W-1:0];
        b.minute = mi[MIN_W-1:0];
        b.second = s[SEC_W-1:0];
        b.open   = op;
        b.high   = hi;
        b.low    = lo;
        b.close  = cl;
        return b;
    endfunction

    // Offer one bar and hold it until accepted. Valid stays up afterwards so
    // back-to-back beats never drop and raise it in the same step.
    task automatic send_bar(input bar_t b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bars_sent++;
    endtask

    // every bar yields at least one beat, so an empty expectation store means
    // the block is idle once the front end has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_settings(input int gap, input bit en);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_GAP;
        cfg_data  <= gap[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_index <= REG_FILL_EN;
        cfg_data  <= CFG_DATA_W'(en);
        @(posedge aclk);
        cfg_we  <= 1'b0;
        cur_gap = gap;
        settings_used++;
    endtask

    // Mostly forward walks of random length (spanning the fill limit), plus
    // repeats, backward steps inside the hour, calendar jumps and raw noise.
    task automatic next_random_bar(output bar_t b);
        int pick, k;
        pick = $urandom_range(0, 99);
        if (pick < 64) begin
            k = $urandom_range(1, cur_gap + 8);
            repeat (k) begin
                cur_min++;
                if (cur_min == 60) begin
                    cur_min = 0;
                    cur_hour++;
                    if (cur_hour == 24) begin
                        cur_hour = 0;
                        cur_day++;
                        if (cur_day > month_days(cur_year, cur_mon)) begin
                            cur_day = 1;
                            cur_mon++;
                            if (cur_mon > 12) begin
                                cur_mon = 1;
                                cur_year++;
                            end
                        end
                    end
                end
            end
        end else if (pick < 84) begin
            // same minute again, or a step back within the hour
            if (pick >= 74) cur_min = $urandom_range(0, cur_min);
        end else if (pick < 91) begin
            cur_year = $urandom_range(1, 9999);
            cur_mon  = $urandom_range(1, 12);
            cur_day  = $urandom_range(1, month_days(cur_year, cur_mon));
            cur_hour = $urandom_range(0, 23);
            cur_min  = $urandom_range(0, 59);
        end
        if (pick < 91) begin
            b = make_bar(cur_year, cur_mon, cur_day, cur_hour, cur_min,
                         $urandom_range(0, 63), pick_price(), pick_price(),
                         pick_price(), pick_price());
        end else begin
            // noise: every field over its full width
            b = make_bar($urandom_range(0, 16383), $urandom_range(0, 15),
                         $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 63), $urandom_range(0, 63),
                         pick_price(), pick_price(), pick_price(), pick_price());
        end
    endtask

    task automatic run_random(input int count);
        bar_t b;
        repeat (count) begin
            next_random_bar(b);
            send_bar(b);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first third: slow sender, very slow receiver
        send_idle_pct = 38;
        recv_idle_pct = 68;
        write_settings(MAX_GAP_RESET, 1'b1);

        // first bar: nothing before it, so no fillers
        send_bar(make_bar(2024, 2, 28, 23, 58, 17, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h3039));
        // four fillers across midnight into Feb 29 of a leap year
        send_bar(make_bar(2024, 2, 29, 0, 3, 45, 32'h1, 32'h2, 32'h3, 32'h4));
        send_bar(make_bar(2024, 2, 29, 23, 59, 0, 32'h10, 32'h20, 32'h30, 32'h40));
        // leap Feb 29 rolls to Mar 1
        send_bar(make_bar(2024, 3, 1, 0, 2, 59, 32'h11, 32'h22, 32'h33, 32'h44));
        send_bar(make_bar(2023, 2, 28, 23, 59, 1, 32'h55, 32'h66, 32'h77, 32'h88));
        // common-year Feb 28 rolls to Mar 1
        send_bar(make_bar(2023, 3, 1, 0, 1, 2, 32'h5, 32'h6, 32'h7, 32'h8));
        send_bar(make_bar(2024, 12, 31, 23, 58, 3, 32'h9, 32'hA, 32'hB, 32'hC));
        // year roll-over inside the fillers
        send_bar(make_bar(2025, 1, 1, 0, 1, 4, 32'hD, 32'hE, 32'hF, 32'h10));
        // gap of one, then gap of zero: no fillers
        send_bar(make_bar(2025, 1, 1, 0, 2, 5, 32'h12, 32'h13, 32'h14, 32'h15));
        send_bar(make_bar(2025, 1, 1, 0, 2, 6, 32'h16, 32'h17, 32'h18, 32'h19));
        // backward in time: fillers still count forward from the previous bar
        send_bar(make_bar(2024, 12, 31, 23, 59, 7, 32'h1A, 32'h1B, 32'h1C, 32'h1D));
        // gap just under the limit: full run of fillers
        send_bar(make_bar(2025, 1, 1, 1, 3, 8, 32'h1E, 32'h1F, 32'h20, 32'h21));
        // gap equal to the limit: none
        send_bar(make_bar(2025, 1, 1, 2, 8, 9, 32'h22, 32'h23, 32'h24, 32'h25));
        // top year, then a month above 12: fillers wrap the year to 0
        send_bar(make_bar(16383, 12, 31, 23, 59, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_bar(make_bar(16383, 13, 1, 0, 2, 10, 32'h26, 32'h27, 32'h28, 32'h29));
        // month 0: no days before the day of month, 31 days long when ticking
        send_bar(make_bar(5, 0, 31, 23, 59, 11, 32'h2A, 32'h2B, 32'h2C, 32'h2D));
        send_bar(make_bar(5, 2, 1, 0, 1, 12, 32'h2E, 32'h2F, 32'h30, 32'h31));
        // month 15, stepping back so the fillers roll it into the next year
        send_bar(make_bar(6, 15, 31, 23, 58, 13, 32'h32, 32'h33, 32'h34, 32'h35));
        send_bar(make_bar(6, 15, 31, 23, 55, 14, 32'h36, 32'h37, 32'h38, 32'h39));
        // hour 31 and minute 63 overflow in the filler tick
        send_bar(make_bar(9, 14, 0, 31, 63, 15, 32'h3A, 32'h3B, 32'h3C, 32'h3D));
        send_bar(make_bar(9, 14, 0, 31, 61, 16, 32'h3E, 32'h3F, 32'h40, 32'h41));
        // all-zero bar and a neighbor
        send_bar(make_bar(0, 0, 0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0));
        send_bar(make_bar(0, 1, 1, 0, 2, 59, 32'h42, 32'h43, 32'h44, 32'h45));
        run_random(15);
        drain();

        // limit above 65: long gaps get capped at the filler maximum
        write_settings(127, 1'b1);
        run_random(20);
        drain();

        // second third: sides swapped
        send_idle_pct = 68;
        recv_idle_pct = 38;
        write_settings(2, 1'b1);
        run_random(20);
        drain();

        write_settings(40, 1'b0);
        run_random(20);
        drain();

        // last third: no idling, then the long output hold
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_settings(0, 1'b1);
        run_random(15);
        drain();

        write_settings(9, 1'b1);
        stall_go <= 1'b1;
        run_random(20);
        drain();

        $display("Covered %0d bars under %0d register settings, %0d filler beats checked.",
                 bars_sent, settings_used, filler_beats);
        $display("Limits 0 to 127, filling off, calendar edge cases, random stalls, one long hold.");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
